// ----- sv/snt_pkg.sv -----
// snt_pkg: shared types and codes for the sorted note table.
// Used by snt_match, sorted_note_table_core and snt_checker.
package snt_pkg;

	typedef struct packed {
		logic [6:0] note;
		logic [7:0] chan;
	} entry_t;

	typedef enum logic [2:0] {
		KIND_ADD      = 3'd0,
		KIND_REM_NOTE = 3'd1,
		KIND_REM_PAIR = 3'd2,
		KIND_REM_CHAN = 3'd3,
		KIND_CLEAR    = 3'd4,
		KIND_READ     = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_FULL      = 2'd2,
		STS_RANGE     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_EV,
		S_SUM0,
		S_SUM1,
		S_SUM2,
		S_DONE
	} state_t;

	// result of the shared compare unit on one stored entry
	typedef struct packed {
		logic ge;   // stored note >= request note
		logic hit;  // entry matches the removal request
	} match_t;

endpackage

// ----- sv/snt_match.sv -----
// snt_match: compare unit shared by every scan step of the table.
// Depends on snt_pkg.
module snt_match
	import snt_pkg::*;
(
	input  entry_t     ent,
	input  logic [2:0] kind,
	input  logic [6:0] note,
	input  logic [7:0] chan,
	output match_t     m
);

	logic note_eq;
	logic chan_eq;

	assign note_eq = (ent.note == note);
	assign chan_eq = (ent.chan == chan);

	always_comb begin
		m.ge = (ent.note >= note);
		case (kind)
			KIND_REM_NOTE: m.hit = note_eq;
			KIND_REM_PAIR: m.hit = note_eq && chan_eq;
			KIND_REM_CHAN: m.hit = chan_eq;
			default:       m.hit = 1'b0;
		endcase
	end

endmodule

// ----- sv/sorted_note_table_core.sv -----
// sorted_note_table_core: table of held notes kept sorted by note number.
// Depends on snt_pkg and snt_match.
//
// Usage:
//   Request channel (item_valid/item_ready) carries kind, note, chan and
//   position. Result channel (result_valid/result_ready) carries one result
//   per request: status, found_at, read data, count and both table ends.
//   item_ready is high only while the sequencer is idle; one request is
//   worked at a time.
// Work per request, with n entries in the table before the request:
//   add:             one scan step for each entry with a note >= the new one;
//                    a new note at position 0 is written with no final compare
//   removals:        n scan steps (one compaction pass over the table)
//   clear, read, add to a full table: no scan, only the summary
//   Each scan step issues the registered memory read in S_RD and then uses
//   the compare unit and the write-back in S_EV. The summary (lowest entry,
//   highest entry, read entry) takes three more reads of the single read port.
// Reset empties the table; the entry memory itself is not cleared and no
//   entry at or above the count is ever shown.
// If the receiver stalls, the finished result waits in the output register;
//   the next request is taken, but its result waits until that one is
//   transferred.
module sorted_note_table_core
	import snt_pkg::*;
#(
	parameter int MAX_NOTES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [2:0] kind,
	input  logic [6:0] note,
	input  logic [7:0] chan,
	input  logic [3:0] position,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [1:0] status,
	output logic [3:0] found_at,
	output logic [6:0] read_note,
	output logic [7:0] read_chan,
	output logic [4:0] count,
	output logic [6:0] low_note,
	output logic [7:0] low_chan,
	output logic [6:0] high_note,
	output logic [7:0] high_chan
);

	localparam int IDX_W  = $clog2(MAX_NOTES);
	localparam int FILL_W = $clog2(MAX_NOTES + 1);
	localparam int CMP_W  = (FILL_W > 4) ? FILL_W : 4;

	entry_t mem [MAX_NOTES];
	entry_t rd_data_q;

	state_t state_q, state_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [FILL_W-1:0] idx_q, idx_d;
	logic [FILL_W-1:0] wr_q, wr_d;
	logic drop_q, drop_d;
	logic [1:0] sts_q, sts_d;
	logic [3:0] found_q, found_d;
	entry_t lo_q, lo_d;
	entry_t hi_q, hi_d;
	logic [2:0] kind_q;
	logic [6:0] note_q;
	logic [7:0] chan_q;
	logic [3:0] pos_q;
	logic result_valid_q;

	logic mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t mem_wdata;
	logic [IDX_W-1:0] rd_addr;
	logic out_load;
	logic accept;
	logic pos_ok;
	entry_t new_ent;
	match_t m;

	assign new_ent = '{note: note_q, chan: chan_q};
	assign accept  = item_valid && item_ready;
	assign pos_ok  = CMP_W'(pos_q) < CMP_W'(fill_q);

	snt_match u_match (
		.ent  (rd_data_q),
		.kind (kind_q),
		.note (note_q),
		.chan (chan_q),
		.m    (m)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			fill_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		wr_q    <= wr_d;
		drop_q  <= drop_d;
		sts_q   <= sts_d;
		found_q <= found_d;
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		if (accept) begin
			kind_q <= kind;
			note_q <= note;
			chan_q <= chan;
			pos_q  <= position;
		end
		if (out_load) begin
			status    <= (kind_q == KIND_READ && !pos_ok) ? STS_RANGE : sts_q;
			found_at  <= found_q;
			read_note <= (kind_q == KIND_READ && pos_ok) ? rd_data_q.note : '0;
			read_chan <= (kind_q == KIND_READ && pos_ok) ? rd_data_q.chan : '0;
			count     <= 5'(fill_q);
			low_note  <= (fill_q != '0) ? lo_q.note : '0;
			low_chan  <= (fill_q != '0) ? lo_q.chan : '0;
			high_note <= (fill_q != '0) ? hi_q.note : '0;
			high_chan <= (fill_q != '0) ? hi_q.chan : '0;
		end
	end

	assign result_valid = result_valid_q;

	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		idx_d      = idx_q;
		wr_d       = wr_q;
		drop_d     = drop_q;
		sts_d      = sts_q;
		found_d    = found_q;
		lo_d       = lo_q;
		hi_d       = hi_q;
		mem_we     = 1'b0;
		mem_waddr  = idx_q[IDX_W-1:0];
		mem_wdata  = new_ent;
		rd_addr    = '0;
		out_load   = 1'b0;
		item_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					sts_d   = STS_OK;
					found_d = '0;
					drop_d  = 1'b0;
					wr_d    = '0;
					idx_d   = '0;
					case (kind)
						KIND_ADD: begin
							if (fill_q == FILL_W'(MAX_NOTES)) begin
								sts_d   = STS_FULL;
								state_d = S_SUM0;
							end else begin
								idx_d   = fill_q;
								state_d = S_RD;
							end
						end
						KIND_REM_NOTE, KIND_REM_PAIR, KIND_REM_CHAN: begin
							state_d = S_RD;
						end
						KIND_CLEAR: begin
							fill_d  = '0;
							state_d = S_SUM0;
						end
						default: state_d = S_SUM0;
					endcase
				end
			end
			S_RD: begin
				if (kind_q == KIND_ADD) begin
					// insertion scans down from the top, shifting notes >= the new one up
					if (idx_q == '0) begin
						mem_we    = 1'b1;
						mem_waddr = '0;
						fill_d    = fill_q + 1'b1;
						state_d   = S_SUM0;
					end else begin
						rd_addr = IDX_W'(idx_q - 1'b1);
						state_d = S_EV;
					end
				end else begin
					if (idx_q == fill_q) begin
						fill_d = wr_q;
						if (kind_q != KIND_REM_CHAN && !drop_q) begin
							sts_d = STS_NOT_FOUND;
						end
						state_d = S_SUM0;
					end else begin
						rd_addr = idx_q[IDX_W-1:0];
						state_d = S_EV;
					end
				end
			end
			S_EV: begin
				if (kind_q == KIND_ADD) begin
					mem_we    = 1'b1;
					mem_waddr = idx_q[IDX_W-1:0];
					if (m.ge) begin
						mem_wdata = rd_data_q;
						idx_d     = idx_q - 1'b1;
						state_d   = S_RD;
					end else begin
						fill_d  = fill_q + 1'b1;
						state_d = S_SUM0;
					end
				end else begin
					// compaction: kept entries are written back at wr_q
					if (m.hit && (kind_q == KIND_REM_CHAN || !drop_q)) begin
						drop_d = 1'b1;
						if (kind_q != KIND_REM_CHAN) begin
							found_d = 4'(idx_q);
						end
					end else begin
						mem_we    = 1'b1;
						mem_waddr = wr_q[IDX_W-1:0];
						mem_wdata = rd_data_q;
						wr_d      = wr_q + 1'b1;
					end
					idx_d   = idx_q + 1'b1;
					state_d = S_RD;
				end
			end
			S_SUM0: begin
				rd_addr = '0;
				state_d = S_SUM1;
			end
			S_SUM1: begin
				lo_d    = rd_data_q;
				rd_addr = IDX_W'(fill_q - 1'b1);
				state_d = S_SUM2;
			end
			S_SUM2: begin
				hi_d    = rd_data_q;
				rd_addr = IDX_W'(pos_q);
				state_d = S_DONE;
			end
			S_DONE: begin
				rd_addr = IDX_W'(pos_q);
				if (!result_valid_q || result_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- sv/snt_checker.sv -----
// snt_checker: port-level checks on sorted_note_table_core, bound below.
// Depends on snt_pkg.
module snt_checker
	import snt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [1:0] status,
	input logic [3:0] found_at,
	input logic [6:0] read_note,
	input logic [7:0] read_chan,
	input logic [4:0] count,
	input logic [6:0] low_note,
	input logic [7:0] low_chan,
	input logic [6:0] high_note,
	input logic [7:0] high_chan
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(status) && $stable(count) && $stable(low_note))
		else $error("result changed while stalled");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("request taken while busy");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && count == 5'd0 |->
			low_note == '0 && low_chan == '0 && high_note == '0 && high_chan == '0)
		else $error("empty table shows end entries");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && count != 5'd0 |-> low_note <= high_note)
		else $error("table ends out of order");

	a_noread: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == STS_RANGE || status == STS_FULL) |->
			read_note == '0 && read_chan == '0 && found_at == '0)
		else $error("read data on failed request");

endmodule

bind sorted_note_table_core snt_checker u_snt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.status       (status),
	.found_at     (found_at),
	.read_note    (read_note),
	.read_chan    (read_chan),
	.count        (count),
	.low_note     (low_note),
	.low_chan     (low_chan),
	.high_note    (high_note),
	.high_chan    (high_chan)
);
